@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/pbm_pkg.sv @@
`timescale 1ns / 1ps
package pbm_pkg;

  localparam int CFG_BITS  = 32;
  localparam int FRAC_BITS = 15;
  localparam int AMP_BITS  = FRAC_BITS + 2;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint ROUND_HALF = 64'sd16384;
  localparam longint AMP_MAX = 64'sd32767;

  // Q1.15 sine of entry k of a table with 2^addr_bits entries per turn,
  // by integer Taylor series in Q30; evaluated at elaboration.
  function automatic int sine_q15(input int unsigned k, input int addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint r;
    x = (64'(k) * TWO_PI_Q30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + ROUND_HALF) >>> FRAC_BITS;
    if (r > AMP_MAX) begin
      r = AMP_MAX;
    end
    return int'(r);
  endfunction

endpackage

@@ rtl/pbm_sine_lut.sv @@
`timescale 1ns / 1ps
module pbm_sine_lut #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic [TABLE_ADDR_BITS-1:0]         addr,
  output logic signed [pbm_pkg::AMP_BITS-1:0] value
);
  import pbm_pkg::*;

  localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
  localparam int IDX_BITS = TABLE_ADDR_BITS - 1;
  localparam int QTR_LEN  = 1 << QTR_BITS;

  logic [FRAC_BITS-1:0] qtab [QTR_LEN+1];
  logic [1:0]           quad;
  logic [QTR_BITS-1:0]  rem;
  logic [IDX_BITS-1:0]  idx;
  logic [FRAC_BITS-1:0] mag;

  for (genvar k = 0; k <= QTR_LEN; k++) begin : g_tab
    assign qtab[k] = FRAC_BITS'(sine_q15(k, TABLE_ADDR_BITS));
  end

  // mirror on odd quadrants, negate on the lower half turn
  always_comb begin
    quad = addr[TABLE_ADDR_BITS-1 -: 2];
    rem  = addr[QTR_BITS-1:0];
    if (quad[0]) begin
      idx = IDX_BITS'(QTR_LEN) - IDX_BITS'(rem);
    end else begin
      idx = IDX_BITS'(rem);
    end
    mag = qtab[idx];
    if (quad[1]) begin
      value = -AMP_BITS'(mag);
    end else begin
      value = AMP_BITS'(mag);
    end
  end

endmodule

@@ rtl/pm_to_bpsk_subcarrier_mixer.sv @@
`timescale 1ns / 1ps
// Phase-modulated to BPSK subcarrier mixer.
// Input channel: in_valid / in_stall with sample_q, the quadrature part of a
// complex sample; a beat moves when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with out_i = -q*sin(theta) and
// out_q = q*cos(theta), rounded and saturated to SAMPLE_BITS.
// Config: cfg_we with cfg_wdata writes the phase step and clears the phase
// accumulator; write only while no beat is in flight.
// Throughput: one beat per cycle while out_stall is low. Two register
// stages: input register with table address, then the result register
// after table and multiplier.
// Reset clears the step, the accumulator and both stage valids; the first
// sample after reset or a step write uses theta zero.
// When the receiver stalls, the result holds and at most one more beat is taken into
// the input register; after that in_stall rises until the result drains.
module pm_to_bpsk_subcarrier_mixer #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pbm_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    sample_q,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    out_i,
  output logic signed [SAMPLE_BITS-1:0]    out_q
);
  import pbm_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + AMP_BITS;
  localparam int SH_BITS   = PROD_BITS + 1 - FRAC_BITS;
  localparam logic [TABLE_ADDR_BITS-1:0] QTR_TURN =
    TABLE_ADDR_BITS'(1 << (TABLE_ADDR_BITS - 2));
  localparam logic signed [SH_BITS-1:0] SAT_MAX =
    SH_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SH_BITS-1:0] SAT_MIN = -SAT_MAX - SH_BITS'(1);

  logic [PHASE_BITS-1:0]             phase_step;
  logic [PHASE_BITS-1:0]             phase_acc;
  logic                              s1_valid;
  logic signed [SAMPLE_BITS-1:0]     s1_q;
  logic [TABLE_ADDR_BITS-1:0]        s1_addr;
  logic                              s2_take;
  logic                              s1_adv;
  logic                              in_acc;
  logic signed [AMP_BITS-1:0]        sin_v;
  logic signed [AMP_BITS-1:0]        cos_v;
  logic signed [AMP_BITS-1:0]        neg_sin;
  logic signed [PROD_BITS-1:0]       prod_i;
  logic signed [PROD_BITS-1:0]       prod_q;
  logic signed [SAMPLE_BITS-1:0]     out_i_next;
  logic signed [SAMPLE_BITS-1:0]     out_q_next;

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS:0] v;
    logic signed [SH_BITS-1:0] sh;
    v  = (PROD_BITS + 1)'(p) + (PROD_BITS + 1)'(ROUND_HALF);
    sh = SH_BITS'(v >>> FRAC_BITS);
    if (sh > SAT_MAX) begin
      return SAMPLE_BITS'(SAT_MAX);
    end else if (sh < SAT_MIN) begin
      return SAMPLE_BITS'(SAT_MIN);
    end
    return SAMPLE_BITS'(sh);
  endfunction

  assign s2_take  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && s2_take;
  assign in_stall = s1_valid && !s2_take;
  assign in_acc   = in_valid && !in_stall;

  pbm_sine_lut #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_sin (
    .addr  (s1_addr),
    .value (sin_v)
  );

  pbm_sine_lut #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_cos (
    .addr  (s1_addr + QTR_TURN),
    .value (cos_v)
  );

  assign neg_sin    = -sin_v;
  assign prod_i     = PROD_BITS'(s1_q) * PROD_BITS'(neg_sin);
  assign prod_q     = PROD_BITS'(s1_q) * PROD_BITS'(cos_v);
  assign out_i_next = round_sat(prod_i);
  assign out_q_next = round_sat(prod_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase_acc  <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_step <= PHASE_BITS'(cfg_wdata);
        phase_acc  <= '0;
      end else if (in_acc) begin
        phase_acc <= phase_acc + phase_step;
      end
      s1_valid <= in_acc || (s1_valid && !s2_take);
      if (s2_take) begin
        out_valid <= s1_valid;
      end
    end
    if (in_acc) begin
      s1_q    <= sample_q;
      s1_addr <= phase_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    end
    if (s1_adv) begin
      out_i <= out_i_next;
      out_q <= out_q_next;
    end
  end

endmodule

@@ rtl/pbm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_i,
  input logic signed [SAMPLE_BITS-1:0] out_q
);

  // back-pressure reaches the input only through a held result
  `ASSERT_IMPL(a_stall_source, clk, rst, in_stall, out_valid && out_stall)

  // reset empties both stages
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)

  `ASSERT_NEXT(a_valid_hold, clk, rst, out_valid && out_stall, out_valid)

  `ASSERT_NEXT(a_data_hold, clk, rst, out_valid && out_stall,
               $stable(out_i) && $stable(out_q))

endmodule

bind pm_to_bpsk_subcarrier_mixer pbm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pbm_checker (.*);

@@ bench/pm_to_bpsk_subcarrier_mixer_tb.sv @@
`timescale 1ns / 1ps
module pm_to_bpsk_subcarrier_mixer_tb;

  localparam int ADDR_BITS = 10;
  localparam int QTR_LEN   = 1 << (ADDR_BITS - 2);
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [pbm_pkg::CFG_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;

  int quarter_sine [0:QTR_LEN];
  logic [31:0] model_step;
  logic [31:0] model_phase;
  mix_result_t expected_mix [$];

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int step_writes = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  pm_to_bpsk_subcarrier_mixer #(
    .PHASE_BITS(32),
    .TABLE_ADDR_BITS(ADDR_BITS),
    .SAMPLE_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_q(sample_q),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_i(out_i),
    .out_q(out_q)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int taylor_sine(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint acc;
    longint r;
    x = (64'(k) * 64'd6746518852 + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 3; n <= 15; n += 2) begin
      term = ((term * x2) >> 30) / 64'(n * (n - 1));
      if (((n - 1) / 2) % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return int'(r);
  endfunction

  function automatic int wave_sine(input logic [ADDR_BITS-1:0] a);
    logic [1:0] quad;
    int r;
    quad = a[ADDR_BITS-1 -: 2];
    r = int'(a[ADDR_BITS-3:0]);
    case (quad)
      2'd0: return quarter_sine[r];
      2'd1: return quarter_sine[QTR_LEN - r];
      2'd2: return -quarter_sine[r];
      default: return -quarter_sine[QTR_LEN - r];
    endcase
  endfunction

  function automatic logic signed [15:0] q15_round_sat(input longint p);
    longint v;
    v = (p + 64'sd16384) >>> 15;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  function automatic mix_result_t mix_sample(input logic signed [15:0] v,
                                             input logic [31:0] phase);
    mix_result_t res;
    logic [ADDR_BITS-1:0] addr;
    longint q;
    longint s;
    longint c;
    addr = phase[31 -: ADDR_BITS];
    q = longint'(v);
    s = longint'(wave_sine(addr));
    c = longint'(wave_sine(addr + ADDR_BITS'(QTR_LEN)));
    res.i = q15_round_sat(-(q * s));
    res.q = q15_round_sat(q * c);
    return res;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] v);
    in_valid <= 1'b1;
    sample_q <= v;
    do @(posedge clk); while (in_stall);
    expected_mix.push_back(mix_sample(v, model_phase));
    model_phase = model_phase + model_step;
    beats_in++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_step(input logic [31:0] v);
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_step = v;
    model_phase = '0;
    step_writes++;
  endtask

  task automatic test_zero_phase_extremes();
    logic signed [15:0] pats [6];
    pats = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh5555, 16'shaaaa};
    foreach (pats[n]) begin
      send_sample(pats[n]);
    end
  endtask

  task automatic test_quadrant_steps();
    write_step(32'h4000_0000);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
  endtask

  task automatic test_step_wrap_and_clear();
    write_step(32'hffff_ffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    write_step(32'hffff_ffff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
  endtask

  task automatic test_random_steps();
    logic [31:0] steps [8];
    steps = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0040_0000,
              32'h8000_0000, $urandom(), $urandom(), $urandom()};
    foreach (steps[n]) begin
      gap_pct = $urandom_range(0, 3) * 10;
      stall_pct = $urandom_range(0, 3) * 10;
      write_step(steps[n]);
      repeat (150) send_sample(pick_sample());
    end
  endtask

  task automatic test_streaming_no_idle();
    gap_pct = 0;
    stall_pct = 0;
    write_step($urandom());
    repeat (150) send_sample(pick_sample());
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beat
    mix_result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (expected_mix.size() == 0) begin
        $display("%0t: unexpected beat out_i=%0d out_q=%0d", $time, out_i, out_q);
        errors++;
      end else begin
        want = expected_mix.pop_front();
        if (out_i !== want.i) begin
          $display("%0t: out_i mismatch expected %0d actual %0d", $time, want.i, out_i);
          errors++;
        end
        if (out_q !== want.q) begin
          $display("%0t: out_q mismatch expected %0d actual %0d", $time, want.q, out_q);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k <= QTR_LEN; k++) begin
      quarter_sine[k] = taylor_sine(k);
    end
    model_step = '0;
    model_phase = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_zero_phase_extremes();
    test_quadrant_steps();
    test_step_wrap_and_clear();
    test_random_steps();
    test_streaming_no_idle();
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Mixed %0d samples into %0d checked beats across %0d phase-step writes,",
             beats_in, beats_out, step_writes);
    $display("including quadrant, wrapping and cleared-accumulator steps under stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pbm_pkg.sv
rtl/pbm_sine_lut.sv
rtl/pm_to_bpsk_subcarrier_mixer.sv
rtl/pbm_checker.sv
bench/pm_to_bpsk_subcarrier_mixer_tb.sv
